// ===== design/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared widths, register indexes, coefficient record and calibration decode
// for the barometric sensor compensation core.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int OUT_FRAC_BITS_DEF = 16;

   localparam int RAW_W    = 24;
   localparam int TEMP_W   = 24;
   localparam int PRES_W   = 27;
   localparam int CSR_W    = 64;
   localparam int CSR_HI_W = 40;
   localparam int CSR_IX_W = 2;
   localparam int CALIB_W  = 2 * CSR_W + CSR_HI_W;

   localparam logic [CSR_IX_W-1:0] CSR_CALIB_LO  = 2'd0;
   localparam logic [CSR_IX_W-1:0] CSR_CALIB_MID = 2'd1;
   localparam logic [CSR_IX_W-1:0] CSR_CALIB_HI  = 2'd2;

   localparam int TEMP_MIN = -8388608;
   localparam int TEMP_MAX = 8388607;

   localparam logic [PRES_W-1:0] PRES_MAX   = 27'h7FF_FFFF;
   // scaled pressure at or above this saturates (100 * 2^27)
   localparam logic [63:0]       PRES_SAT_M = 64'd13421772800;
   // floor(n / 25) = (n * DIV_RECIP) >> DIV_SHIFT, exact for any 32-bit n
   localparam logic [32:0]       DIV_RECIP  = 33'd5497558139;
   localparam int                DIV_SHIFT  = 37;

   typedef struct packed {
      logic        [15:0] t1;
      logic        [15:0] t2;
      logic signed [7:0]  t3;
      logic signed [15:0] p1;
      logic signed [15:0] p2;
      logic signed [7:0]  p3;
      logic signed [7:0]  p4;
      logic        [15:0] p5;
      logic        [15:0] p6;
      logic signed [7:0]  p7;
      logic signed [7:0]  p8;
      logic signed [15:0] p9;
      logic signed [7:0]  p10;
      logic signed [7:0]  p11;
   } coef_type;

   function automatic coef_type decode_calib(input logic [CALIB_W-1:0] cb);
      coef_type c;
      c.t1  = cb[15:0];
      c.t2  = cb[31:16];
      c.t3  = cb[39:32];
      c.p1  = cb[55:40];
      c.p2  = cb[71:56];
      c.p3  = cb[79:72];
      c.p4  = cb[87:80];
      c.p5  = cb[103:88];
      c.p6  = cb[119:104];
      c.p7  = cb[127:120];
      c.p8  = cb[135:128];
      c.p9  = cb[151:136];
      c.p10 = cb[159:152];
      c.p11 = cb[167:160];
      return c;
   endfunction

endpackage

// ===== design/bsc_ifs.sv =====
// ----------------------------------------------------------------------------
// bsc_req_if / bsc_rsp_if
// Valid/ready channels for raw sample words and compensated result words.
// ----------------------------------------------------------------------------
interface bsc_req_if;
   logic                      valid;
   logic                      ready;
   logic [bsc_pkg::RAW_W-1:0] raw_pressure;
   logic [bsc_pkg::RAW_W-1:0] raw_temperature;

   modport source (output valid, output raw_pressure, output raw_temperature, input ready);
   modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bsc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [bsc_pkg::TEMP_W-1:0] temperature_c;
   logic        [bsc_pkg::PRES_W-1:0] pres_hpa;

   modport source (output valid, output temperature_c, output pres_hpa, input ready);
   modport sink   (input valid, input temperature_c, input pres_hpa, output ready);
endinterface

// ===== design/bsc_delay.sv =====
// ----------------------------------------------------------------------------
// bsc_delay
// Fixed-depth enabled shift line that keeps side data aligned with the
// multiplier pipeline.
// ----------------------------------------------------------------------------
module bsc_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 3
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] pipe_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   assign q = pipe_ff[DEPTH-1];

endmodule

// ===== design/bsc_mulrnd.sv =====
// ----------------------------------------------------------------------------
// bsc_mulrnd
// Three-stage signed multiply, round half away from zero by 2^SHIFT, plus an
// addend: split-operand partial products, sum with bias, shift and add.
// ----------------------------------------------------------------------------
module bsc_mulrnd #(
   parameter int WA    = 8,
   parameter int WB    = 61,
   parameter int SHIFT = 23,
   parameter int WO    = 46
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [WA-1:0] a,
   input  logic signed [WB-1:0] b,
   input  logic signed [WO-1:0] addend,
   output logic signed [WO-1:0] y
);

   localparam int LA = WA / 2;
   localparam int HA = WA - LA;
   localparam int LB = WB / 2;
   localparam int HB = WB - LB;
   localparam int WP = WA + WB;

   logic signed [LA:0]   al;
   logic signed [HA-1:0] ah;
   logic signed [LB:0]   bl;
   logic signed [HB-1:0] bh;

   logic signed [LA+LB+1:0] ll_in, ll_ff;
   logic signed [LA+HB:0]   lh_in, lh_ff;
   logic signed [HA+LB:0]   hl_in, hl_ff;
   logic signed [HA+HB-1:0] hh_in, hh_ff;
   logic                    neg_ff;
   logic signed [WO-1:0]    add1_ff, add2_ff;

   logic signed [WP-1:0] full;
   logic signed [WP-1:0] bias;
   logic signed [WP-1:0] acc_in, acc_ff;
   logic signed [WP-1:0] shr;
   logic signed [WO-1:0] y_in, y_ff;

   assign al = $signed({1'b0, a[LA-1:0]});
   assign ah = a[WA-1:LA];
   assign bl = $signed({1'b0, b[LB-1:0]});
   assign bh = b[WB-1:LB];

   always_comb begin
      ll_in = al * bl;
      lh_in = al * bh;
      hl_in = ah * bl;
      hh_in = ah * bh;
   end

   // bias of half minus one for a negative product rounds ties away from zero
   always_comb begin
      full = (WP'(hh_ff) <<< (LA + LB)) + (WP'(hl_ff) <<< LA)
           + (WP'(lh_ff) <<< LB) + WP'(ll_ff);
      bias = (WP'(1) <<< (SHIFT - 1)) - $signed({{(WP-1){1'b0}}, neg_ff});
      acc_in = full + bias;
   end

   always_comb begin
      shr  = acc_ff >>> SHIFT;
      y_in = WO'(shr) + add2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff   <= ll_in;
         lh_ff   <= lh_in;
         hl_ff   <= hl_in;
         hh_ff   <= hh_in;
         neg_ff  <= a[WA-1] ^ b[WB-1];
         add1_ff <= addend;
         acc_ff  <= acc_in;
         add2_ff <= add1_ff;
         y_ff    <= y_in;
      end
   end

   assign y = y_ff;

endmodule

// ===== design/bsc_pres_round.sv =====
// ----------------------------------------------------------------------------
// bsc_pres_round
// Converts the Q32 pressure sum in Pa to hPa with FRAC fraction bits: round
// to nearest, clamp at zero and at full scale, divide by 100 via reciprocal.
// ----------------------------------------------------------------------------
module bsc_pres_round #(
   parameter int FRAC = bsc_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [63:0]           sum,
   output logic [bsc_pkg::PRES_W-1:0]   q
);

   localparam int SH = 32 - FRAC;
   localparam logic signed [63:0] HALF = 64'sd50 <<< SH;

   logic signed [63:0] m;
   logic [31:0]        n_in, n_ff;
   logic               pos_in, pos_ff, pos2_ff;
   logic               sat_in, sat_ff, sat2_ff;
   logic [64:0]        prod_in, prod_ff;

   // divide by 4 here, by 25 through the reciprocal next stage
   always_comb begin
      m      = (sum + HALF) >>> SH;
      pos_in = !sum[63] && (sum != 64'sd0);
      sat_in = $unsigned(m) >= bsc_pkg::PRES_SAT_M;
      n_in   = m[33:2];
   end

   assign prod_in = 65'(n_ff) * 65'(bsc_pkg::DIV_RECIP);

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff    <= n_in;
         pos_ff  <= pos_in;
         sat_ff  <= sat_in;
         prod_ff <= prod_in;
         pos2_ff <= pos_ff;
         sat2_ff <= sat_ff;
      end
   end

   always_comb begin
      if (!pos2_ff) begin
         q = '0;
      end else if (sat2_ff) begin
         q = bsc_pkg::PRES_MAX;
      end else begin
         q = prod_ff[bsc_pkg::DIV_SHIFT +: bsc_pkg::PRES_W];
      end
   end

endmodule

// ===== design/baro_sensor_compensation_core.sv =====
// ----------------------------------------------------------------------------
// baro_sensor_compensation_core
// Pressure/temperature compensation of raw barometer samples.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one word of raw pressure and raw temperature (24 bits each).
//   rsp returns one word per request: temperature in degrees C (signed) and
//   pressure in hPa (unsigned), both with OUT_FRAC_BITS fraction bits,
//   rounded to nearest and saturated.
//   csr_we/csr_index/csr_wdata load the three calibration registers (bytes
//   0-7, 8-15, 16-20). Write them only while no word is in flight.
//   A word accepted on req passes through these stages in order: three
//   stages form the linearized temperature, four rounded multiplies of three
//   stages each run in series behind it, then two divide-by-100 stages and
//   the response register. One word is taken every cycle unless rsp stalls.
//   When rsp is stalled the whole pipeline holds and req.ready drops; no
//   word is lost or repeated. Reset (synchronous) clears the calibration
//   registers and all valid bits.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_core #(
   parameter int OUT_FRAC_BITS = bsc_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [bsc_pkg::CSR_IX_W-1:0]  csr_index,
   input  logic [bsc_pkg::CSR_W-1:0]     csr_wdata,
   bsc_req_if.sink                       req,
   bsc_rsp_if.source                     rsp
);

   localparam int TL_W = 61;
   localparam int TS   = 48 - OUT_FRAC_BITS;
   localparam int NV   = 17;
   localparam int H1_W = 46;
   localparam int H2_W = 56;
   localparam int H3_W = 58;
   localparam int G1_W = 62;
   localparam int G2_W = 60;
   localparam int G3_W = 62;
   localparam int K_W  = 61;
   localparam int KT_W = 52;
   localparam int CB_W = 48;
   localparam int RAW  = bsc_pkg::RAW_W;

   // calibration registers
   logic [bsc_pkg::CSR_W-1:0]    calib_lo_ff, calib_mid_ff;
   logic [bsc_pkg::CSR_HI_W-1:0] calib_hi_ff;
   bsc_pkg::coef_type            coef;

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_lo_ff  <= '0;
         calib_mid_ff <= '0;
         calib_hi_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            bsc_pkg::CSR_CALIB_LO:  calib_lo_ff  <= csr_wdata;
            bsc_pkg::CSR_CALIB_MID: calib_mid_ff <= csr_wdata;
            bsc_pkg::CSR_CALIB_HI:  calib_hi_ff  <= csr_wdata[bsc_pkg::CSR_HI_W-1:0];
            default: ;
         endcase
      end
   end

   assign coef = bsc_pkg::decode_calib({calib_hi_ff, calib_mid_ff, calib_lo_ff});

   // flow control: every stage advances together
   logic          adv;
   logic [NV-1:0] vld_in, vld_ff;
   logic          rsp_vld_ff;

   assign adv       = !rsp_vld_ff || rsp.ready;
   assign req.ready = adv;
   assign vld_in    = {vld_ff[NV-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= vld_in;
         rsp_vld_ff <= vld_ff[NV-1];
      end
   end

   // front end: temperature offset, squares, linearized temperature
   logic signed [24:0]    d_in, d_ff;
   logic [RAW-1:0]        ua_ff, ub_ff, uc_ff;
   logic signed [41:0]    pa_in, pa_ff;
   logic signed [49:0]    pb_in, pb_ff;
   logic [47:0]           u2_in, u2b_ff, u2c_ff;
   logic signed [32:0]    pu_in, pub_ff, puc_ff;
   logic signed [57:0]    pbt;
   logic signed [TL_W-1:0] tl_in, tl_ff;

   always_comb begin
      d_in  = $signed({1'b0, req.raw_temperature}) - $signed({1'b0, coef.t1, 8'h00});
      pa_in = d_ff * $signed({1'b0, coef.t2});
      pb_in = d_ff * d_ff;
      u2_in = ua_ff * ua_ff;
      pu_in = coef.p11 * $signed({1'b0, ua_ff});
      pbt   = pb_ff * coef.t3;
      tl_in = (TL_W'(pa_ff) <<< 18) + TL_W'(pbt);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff   <= d_in;
         ua_ff  <= req.raw_pressure;
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         u2b_ff <= u2_in;
         pub_ff <= pu_in;
         ub_ff  <= ua_ff;
         tl_ff  <= tl_in;
         u2c_ff <= u2b_ff;
         puc_ff <= pub_ff;
         uc_ff  <= ub_ff;
      end
   end

   // temperature output: round ties up, saturate
   logic signed [TL_W-1:0]         trd;
   logic signed [bsc_pkg::TEMP_W-1:0] temp_in, temp_q;

   always_comb begin
      trd = (tl_ff + (TL_W'(1) <<< (TS - 1))) >>> TS;
      if (trd < TL_W'(bsc_pkg::TEMP_MIN)) begin
         temp_in = bsc_pkg::TEMP_W'(bsc_pkg::TEMP_MIN);
      end else if (trd > TL_W'(bsc_pkg::TEMP_MAX)) begin
         temp_in = bsc_pkg::TEMP_W'(bsc_pkg::TEMP_MAX);
      end else begin
         temp_in = trd[bsc_pkg::TEMP_W-1:0];
      end
   end

   bsc_delay #(.W(bsc_pkg::TEMP_W), .DEPTH(14)) u_temp_dly (
      .clock(clock), .en(adv), .d(temp_in), .q(temp_q));

   // aligned copies of tl, U^2 and U
   logic [TL_W-1:0] tl3_q, tl6_q;
   logic [47:0]     u2_3_q;
   logic [RAW-1:0]  u9_q;

   bsc_delay #(.W(TL_W), .DEPTH(3)) u_tl3_dly (
      .clock(clock), .en(adv), .d(tl_ff), .q(tl3_q));
   bsc_delay #(.W(TL_W), .DEPTH(3)) u_tl6_dly (
      .clock(clock), .en(adv), .d(tl3_q), .q(tl6_q));
   bsc_delay #(.W(48), .DEPTH(3)) u_u2_dly (
      .clock(clock), .en(adv), .d(u2c_ff), .q(u2_3_q));
   bsc_delay #(.W(RAW), .DEPTH(9)) u_u_dly (
      .clock(clock), .en(adv), .d(uc_ff), .q(u9_q));

   // polynomial chains
   logic signed [H1_W-1:0] h1;
   logic signed [H2_W-1:0] h2;
   logic signed [H3_W-1:0] h3;
   logic signed [G1_W-1:0] g1;
   logic signed [G2_W-1:0] g2;
   logic signed [G3_W-1:0] g3;
   logic signed [K_W-1:0]  kk;
   logic signed [KT_W-1:0] kt;
   logic signed [CB_W-1:0] cub;
   logic signed [63:0]     psum;

   bsc_mulrnd #(.WA(8), .WB(TL_W), .SHIFT(23), .WO(H1_W)) u_h1 (
      .clock(clock), .en(adv), .a(coef.p8), .b(tl_ff),
      .addend(H1_W'(coef.p7) <<< 32), .y(h1));

   bsc_mulrnd #(.WA(8), .WB(TL_W), .SHIFT(5), .WO(G1_W)) u_g1 (
      .clock(clock), .en(adv), .a(coef.p4), .b(tl_ff),
      .addend(G1_W'(coef.p3) <<< 48), .y(g1));

   bsc_mulrnd #(.WA(8), .WB(TL_W), .SHIFT(6), .WO(K_W)) u_k (
      .clock(clock), .en(adv), .a(coef.p10), .b(tl_ff),
      .addend(K_W'(coef.p9) <<< 42), .y(kk));

   bsc_mulrnd #(.WA(33), .WB(49), .SHIFT(33), .WO(CB_W)) u_cub (
      .clock(clock), .en(adv), .a(puc_ff), .b($signed({1'b0, u2c_ff})),
      .addend('0), .y(cub));

   bsc_mulrnd #(.WA(H1_W), .WB(TL_W), .SHIFT(48), .WO(H2_W)) u_h2 (
      .clock(clock), .en(adv), .a(h1), .b($signed(tl3_q)),
      .addend($signed(H2_W'(coef.p6) <<< 34)), .y(h2));

   bsc_mulrnd #(.WA(G1_W), .WB(TL_W), .SHIFT(60), .WO(G2_W)) u_g2 (
      .clock(clock), .en(adv), .a(g1), .b($signed(tl3_q)),
      .addend((G2_W'(coef.p2) - G2_W'(16384)) <<< 39), .y(g2));

   bsc_mulrnd #(.WA(K_W), .WB(49), .SHIFT(58), .WO(KT_W)) u_kt (
      .clock(clock), .en(adv), .a(kk), .b($signed({1'b0, u2_3_q})),
      .addend(KT_W'(cub)), .y(kt));

   // fold the square and cube terms into the offset chain
   bsc_mulrnd #(.WA(H2_W), .WB(TL_W), .SHIFT(56), .WO(H3_W)) u_h3 (
      .clock(clock), .en(adv), .a(h2), .b($signed(tl6_q)),
      .addend($signed(H3_W'(coef.p5) <<< 35) + H3_W'(kt)), .y(h3));

   bsc_mulrnd #(.WA(G2_W), .WB(TL_W), .SHIFT(56), .WO(G3_W)) u_g3 (
      .clock(clock), .en(adv), .a(g2), .b($signed(tl6_q)),
      .addend((G3_W'(coef.p1) - G3_W'(16384)) <<< 40), .y(g3));

   bsc_mulrnd #(.WA(G3_W), .WB(RAW+1), .SHIFT(28), .WO(64)) u_fin (
      .clock(clock), .en(adv), .a(g3), .b($signed({1'b0, u9_q})),
      .addend(64'(h3)), .y(psum));

   logic [bsc_pkg::PRES_W-1:0] pres_q;

   bsc_pres_round #(.FRAC(OUT_FRAC_BITS)) u_pres (
      .clock(clock), .en(adv), .sum(psum), .q(pres_q));

   // response register
   logic signed [bsc_pkg::TEMP_W-1:0] rsp_temp_ff;
   logic        [bsc_pkg::PRES_W-1:0] rsp_pres_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_temp_ff <= temp_q;
         rsp_pres_ff <= pres_q;
      end
   end

   assign rsp.valid         = rsp_vld_ff;
   assign rsp.temperature_c = rsp_temp_ff;
   assign rsp.pres_hpa      = rsp_pres_ff;

   // checks
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during stall");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("response valid after reset");

   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      (adv && vld_ff[NV-1]) |=> rsp.valid)
      else $error("finished word not presented");

endmodule

// ===== tb/sv/bsc_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bsc_result_checker
// Watches the calibration port and both channels of the compensation core,
// predicts temperature and pressure for every accepted sample word and
// compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module bsc_result_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [bsc_pkg::CSR_IX_W-1:0] csr_index,
   input  logic [bsc_pkg::CSR_W-1:0]    csr_wdata,
   bsc_req_if                           req_mon,
   bsc_rsp_if                           rsp_mon,
   output int                           mismatch_count,
   output int                           words_in_flight
);
   import bsc_pkg::*;

   localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic        [PRES_W-1:0] pres;
   } comp_word_type;

   logic [CSR_W-1:0]    calib_lo, calib_mid;
   logic [CSR_HI_W-1:0] calib_hi;
   comp_word_type       comp_queue[$];

   function automatic longint calib_byte(input int k);
      logic [CALIB_W-1:0] cb;
      cb = {calib_hi, calib_mid, calib_lo};
      return longint'({56'd0, cb[8*k +: 8]});
   endfunction

   function automatic longint calib_u16(input int k);
      return calib_byte(k) + 256 * calib_byte(k + 1);
   endfunction

   function automatic longint calib_s16(input int k);
      longint u;
      u = calib_u16(k);
      return (u >= 32768) ? u - 65536 : u;
   endfunction

   function automatic longint calib_s8(input int k);
      longint u;
      u = calib_byte(k);
      return (u >= 128) ? u - 256 : u;
   endfunction

   // full-width product, shifted with rounding half away from zero
   function automatic longint mul_round(input longint a, input longint b, input int s);
      logic [63:0]  ua, ub;
      logic [127:0] prod;
      logic [63:0]  mag;
      bit           neg;
      ua   = (a < 0) ? 64'(0 - a) : 64'(a);
      ub   = (b < 0) ? 64'(0 - b) : 64'(b);
      neg  = (a < 0) != (b < 0);
      prod = {64'd0, ua} * {64'd0, ub};
      prod = prod + (128'd1 << (s - 1));
      prod = prod >> s;
      mag  = (prod > 128'(I64_MAX)) ? 64'(I64_MAX) : prod[63:0];
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic comp_word_type compensate(input logic [RAW_W-1:0] raw_p,
                                                input logic [RAW_W-1:0] raw_t);
      comp_word_type w;
      longint u, v, d, tl, temp, h, g, k, u2, total, den, q;
      longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
      t1 = calib_u16(0);  t2 = calib_u16(2);  t3 = calib_s8(4);
      p1 = calib_s16(5);  p2 = calib_s16(7);  p3 = calib_s8(9);   p4 = calib_s8(10);
      p5 = calib_u16(11); p6 = calib_u16(13); p7 = calib_s8(15);  p8 = calib_s8(16);
      p9 = calib_s16(17); p10 = calib_s8(19); p11 = calib_s8(20);
      u = longint'({40'd0, raw_p});
      v = longint'({40'd0, raw_t});
      d  = v - t1 * 256;
      tl = d * t2 * (64'sd1 <<< 18) + d * d * t3;
      // round to nearest, ties up: floor of the biased value
      temp = (tl + (64'sd1 <<< (47 - OUT_FRAC_BITS_DEF))) >>> (48 - OUT_FRAC_BITS_DEF);
      if (temp < TEMP_MIN) temp = TEMP_MIN;
      if (temp > TEMP_MAX) temp = TEMP_MAX;

      h = mul_round(p8, tl, 23) + p7 * (64'sd1 <<< 32);
      h = mul_round(h, tl, 48) + p6 * (64'sd1 <<< 34);
      h = mul_round(h, tl, 56) + p5 * (64'sd1 <<< 35);
      total = h;

      g = mul_round(p4, tl, 5) + p3 * (64'sd1 <<< 48);
      g = mul_round(g, tl, 60) + (p2 - 16384) * (64'sd1 <<< 39);
      g = mul_round(g, tl, 56) + (p1 - 16384) * (64'sd1 <<< 40);
      total += mul_round(g, u, 28);

      u2 = u * u;
      k  = mul_round(p10, tl, 6) + p9 * (64'sd1 <<< 42);
      total += mul_round(k, u2, 58);
      total += mul_round(p11 * u, u2, 33);

      if (total <= 0) begin
         q = 0;
      end else begin
         den = 100 * (64'sd1 <<< (32 - OUT_FRAC_BITS_DEF));
         q   = (total + den / 2) / den;
         if (q > longint'(PRES_MAX)) q = longint'(PRES_MAX);
      end
      w.temp = temp[TEMP_W-1:0];
      w.pres = q[PRES_W-1:0];
      return w;
   endfunction

   always @(posedge clock) begin
      comp_word_type want;
      int            errs;
      errs = 0;
      if (reset) begin
         calib_lo  <= '0;
         calib_mid <= '0;
         calib_hi  <= '0;
         comp_queue.delete();
         mismatch_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CALIB_LO:  calib_lo  <= csr_wdata;
               CSR_CALIB_MID: calib_mid <= csr_wdata;
               CSR_CALIB_HI:  calib_hi  <= csr_wdata[CSR_HI_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            comp_queue.push_back(compensate(req_mon.raw_pressure, req_mon.raw_temperature));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (comp_queue.size() == 0) begin
               $display("%0t: unexpected result word temp=%0d pres=%0d", $time,
                        rsp_mon.temperature_c, rsp_mon.pres_hpa);
               errs = errs + 1;
            end else begin
               want = comp_queue.pop_front();
               if (want.temp !== rsp_mon.temperature_c) begin
                  $display("%0t: temperature_c expected %0d actual %0d", $time,
                           want.temp, rsp_mon.temperature_c);
                  errs = errs + 1;
               end
               if (want.pres !== rsp_mon.pres_hpa) begin
                  $display("%0t: pres_hpa expected %0d actual %0d", $time,
                           want.pres, rsp_mon.pres_hpa);
                  errs = errs + 1;
               end
            end
         end
         if (errs != 0)
            mismatch_count <= mismatch_count + errs;
      end
      words_in_flight <= comp_queue.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the barometric compensation core: loads several calibration
// sets (all zero, all ones, random), sends directed and random sample words
// under varying sender idle and receiver stall rates, and reports the verdict
// from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb;
   import bsc_pkg::*;

   localparam logic [CSR_IX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 25;
   localparam int WORDS_PER_SET = 130;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [CSR_IX_W-1:0] csr_index;
   logic [CSR_W-1:0]    csr_wdata;
   int                  idle_pct, stall_pct;
   int                  mismatch_count, words_in_flight;
   int                  cycle_count;
   logic [15:0]         cur_t1;

   bsc_req_if req_ch ();
   bsc_rsp_if rsp_ch ();

   baro_sensor_compensation_core DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

   bsc_result_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .mismatch_count  (mismatch_count),
      .words_in_flight (words_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

   task automatic send_word(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.raw_pressure    <= raw_p;
      req_ch.raw_temperature <= raw_t;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // drop valid, let the pipeline empty, then wait out its depth
   task automatic drain();
      req_ch.valid <= 1'b0;
      wait (words_in_flight == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_calib(input logic [CSR_W-1:0] lo, input logic [CSR_W-1:0] mid,
                             input logic [CSR_W-1:0] hi);
      csr_write(CSR_CALIB_LO, lo);
      csr_write(CSR_CALIB_MID, mid);
      csr_write(CSR_CALIB_HI, hi);
      cur_t1 = lo[15:0];
   endtask

   task automatic send_extremes();
      send_word('0, '0);
      send_word('1, '1);
      send_word('0, '1);
      send_word('1, '0);
      send_word(24'h800000, {cur_t1, 8'h00});
   endtask

   function automatic logic [RAW_W-1:0] rand_raw();
      return RAW_W'($urandom);
   endfunction

   // mostly temperatures near the calibrated zero point, some anywhere
   function automatic logic [RAW_W-1:0] rand_temp();
      int v;
      if ($urandom_range(99) < 60) begin
         v = int'({cur_t1, 8'h00}) + $urandom_range(2 * 65536) - 65536;
         if (v < 0) v = 0;
         if (v > 24'hFFFFFF) v = 24'hFFFFFF;
         return RAW_W'(v);
      end
      return rand_raw();
   endfunction

   initial begin
      cycle_count            = 0;
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = CSR_CALIB_LO;
      csr_wdata              = '0;
      req_ch.valid           = 1'b0;
      req_ch.raw_pressure    = '0;
      req_ch.raw_temperature = '0;
      rsp_ch.ready           = 1'b1;
      idle_pct               = 0;
      stall_pct              = 0;
      cur_t1                 = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset calibration, then extremes and typical sets
      send_extremes();
      drain();
      load_calib('1, '1, '1);
      send_extremes();
      drain();
      load_calib({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      send_extremes();
      drain();
      // out-of-range index must leave the calibration alone
      csr_write(CSR_UNUSED, '1);
      send_extremes();

      for (int set = 0; set < 8; set++) begin
         drain();
         case (set % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 76; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 76; end
            default: begin idle_pct = 14; stall_pct = 14; end
         endcase
         if (set == 4)
            load_calib('0, '0, '0);
         else if (set == 5)
            load_calib('1, '1, '1);
         else
            load_calib({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
         for (int n = 0; n < WORDS_PER_SET; n++) begin
            if (set == 2 && n == WORDS_PER_SET / 2) begin
               req_ch.valid <= 1'b0;
               wait (words_in_flight == 0);
               @(negedge clock);
            end
            send_word(rand_raw(), rand_temp());
         end
      end

      drain();
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
